/* sv/uart_rx_with_rts_send_gate_macros.svh */
// assertion macros shared by the uart receiver and send gate modules
`ifndef UART_RX_WITH_RTS_SEND_GATE_MACROS_SVH
`define UART_RX_WITH_RTS_SEND_GATE_MACROS_SVH
`ifndef SYNTH
// same-cycle implication, sampled on clk, off during reset
`define URTS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("urts check failed");
// next-cycle implication, sampled on clk, off during reset
`define URTS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("urts check failed");
`else
`define URTS_ASSERT_NOW(label, ante, cons)
`define URTS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* sv/urts_pkg.sv */
// types and constants for the uart receiver with rts send gate
package urts_pkg;

    localparam int DATA_W     = 8;
    localparam int CFG_W      = 8;
    localparam int CFG_ADDR_W = 1;
    localparam int TICK_W     = 9;
    localparam int BITS_W     = 4;

    localparam logic [CFG_ADDR_W-1:0] CFG_BIT_PERIOD  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_RTS_HOLDOFF = 1'b1;

    localparam logic [CFG_W-1:0]  BIT_PERIOD_RST  = 8'd13;
    localparam logic [CFG_W-1:0]  RTS_HOLDOFF_RST = 8'd17;
    localparam logic [TICK_W-1:0] TICK_RST        = 9'd1;
    localparam logic [TICK_W-1:0] TICK_MAX        = 9'd511;
    localparam logic [7:0]        GAP_MAX         = 8'd255;
    localparam logic [BITS_W-1:0] DATA_BITS       = 4'd8;

    typedef enum logic [2:0] {
        PH_WAIT = 3'b001,
        PH_DATA = 3'b010,
        PH_STOP = 3'b100
    } rx_phase_t;

    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] data;
    } rx_res_t;

    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] data;
        logic              dropped;
    } send_res_t;

endpackage

/* sv/urts_rx.sv */
// 8n1 serial receiver, one tick per step, result registered on the step
`include "uart_rx_with_rts_send_gate_macros.svh"
module urts_rx (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                step,
    input  logic                                line_bit,
    input  logic [urts_pkg::CFG_W-1:0]          bit_period,
    output urts_pkg::rx_res_t                   res
);

    urts_pkg::rx_phase_t                phase_reg, phase_next;
    logic [urts_pkg::TICK_W-1:0]        tick_reg, tick_next;
    logic [urts_pkg::BITS_W-1:0]        bits_reg, bits_next;
    logic [urts_pkg::DATA_W-1:0]        shift_reg, shift_next;
    urts_pkg::rx_res_t                  res_reg, res_next;

    logic                               sample;
    logic [urts_pkg::DATA_W-1:0]        shifted;
    logic [urts_pkg::BITS_W-1:0]        bits_inc;

    always_comb
    begin
        sample   = tick_reg >= {1'b0, bit_period};
        shifted  = {line_bit, shift_reg[urts_pkg::DATA_W-1:1]};
        bits_inc = bits_reg + urts_pkg::BITS_W'(1);

        phase_next = phase_reg;
        tick_next  = (tick_reg == urts_pkg::TICK_MAX) ? tick_reg
                                                      : tick_reg + urts_pkg::TICK_W'(1);
        bits_next  = bits_reg;
        shift_next = shift_reg;
        res_next   = '0;

        case (phase_reg)
            urts_pkg::PH_DATA:
            begin
                if (sample)
                begin
                    shift_next = shifted;
                    tick_next  = urts_pkg::TICK_W'(1);
                    bits_next  = bits_inc;
                    if (bits_inc >= urts_pkg::DATA_BITS)
                    begin
                        phase_next = urts_pkg::PH_STOP;
                        // zero byte is consumed silently
                        if (shifted != '0)
                        begin
                            res_next.valid = 1'b1;
                            res_next.data  = shifted;
                        end
                    end
                end
            end
            urts_pkg::PH_STOP:
            begin
                if (sample)
                    phase_next = urts_pkg::PH_WAIT;
            end
            default:
            begin
                phase_next = urts_pkg::PH_WAIT;
                if (!line_bit)
                begin
                    phase_next = urts_pkg::PH_DATA;
                    tick_next  = '0;
                    bits_next  = '0;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= urts_pkg::PH_WAIT;
            tick_reg  <= urts_pkg::TICK_RST;
            bits_reg  <= '0;
            shift_reg <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            bits_reg  <= bits_next;
            shift_reg <= shift_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
            res_reg <= res_next;
    end

    assign res = res_reg;

    `URTS_ASSERT_NEXT(a_rx_byte_enters_stop, step && res_next.valid, phase_reg == urts_pkg::PH_STOP)
    `URTS_ASSERT_NOW(a_rx_bits_bound, phase_reg == urts_pkg::PH_DATA, bits_reg < urts_pkg::DATA_BITS)
    `URTS_ASSERT_NOW(a_rx_stop_full_byte, phase_reg == urts_pkg::PH_STOP, bits_reg == urts_pkg::DATA_BITS)

endmodule

/* sv/urts_send.sv */
// host byte queue in a synchronous memory with the rts send gate and gap counter
`include "uart_rx_with_rts_send_gate_macros.svh"
module urts_send #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                step,
    input  logic                                rts_n,
    input  logic [urts_pkg::DATA_W-1:0]         host_byte,
    input  logic [urts_pkg::CFG_W-1:0]          rts_holdoff,
    output urts_pkg::send_res_t                 res
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);

    logic [urts_pkg::DATA_W-1:0] mem [QUEUE_DEPTH];
    logic [urts_pkg::DATA_W-1:0] mem_q;

    logic [PTR_W-1:0]            head_reg, head_next;
    logic [PTR_W-1:0]            tail_reg, tail_next;
    logic [CNT_W-1:0]            used_reg, used_next;
    logic [7:0]                  gap_reg, gap_next;
    logic                        armed_reg, armed_next;

    logic                        fwd_reg;
    logic [urts_pkg::DATA_W-1:0] fwd_byte_reg;
    logic                        valid_reg;
    logic                        dropped_reg;

    logic                        has_byte, full, enq, dropped, release_now, fwd;
    logic [CNT_W-1:0]            used_enq;
    logic [7:0]                  gap_inc;

    function automatic logic [PTR_W-1:0] slot_inc(input logic [PTR_W-1:0] p);
        return (p == LAST_SLOT) ? '0 : p + PTR_W'(1);
    endfunction

    always_comb
    begin
        has_byte    = host_byte != '0;
        full        = used_reg == FULL_CNT;
        enq         = has_byte && !full;
        dropped     = has_byte && full;
        used_enq    = used_reg + CNT_W'(enq);
        release_now = armed_reg && (used_enq != '0);
        gap_inc     = (gap_reg == urts_pkg::GAP_MAX) ? gap_reg : gap_reg + 8'd1;
        gap_next    = release_now ? 8'd0 : gap_inc;
        armed_next  = !rts_n && (gap_next > rts_holdoff);
        head_next   = release_now ? slot_inc(head_reg) : head_reg;
        tail_next   = enq ? slot_inc(tail_reg) : tail_reg;
        used_next   = used_enq - CNT_W'(release_now);
        // byte written and released in the same tick never reaches the read port
        fwd         = enq && release_now && (head_reg == tail_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            used_reg  <= '0;
            gap_reg   <= '0;
            armed_reg <= 1'b0;
        end
        else if (step)
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            used_reg  <= used_next;
            gap_reg   <= gap_next;
            armed_reg <= armed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && enq)
            mem[tail_reg] <= host_byte;
        if (step && release_now)
            mem_q <= mem[head_reg];
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            fwd_reg      <= fwd;
            fwd_byte_reg <= host_byte;
            valid_reg    <= release_now;
            dropped_reg  <= dropped;
        end
    end

    always_comb
    begin
        res.valid   = valid_reg;
        res.dropped = dropped_reg;
        if (!valid_reg)
            res.data = '0;
        else if (fwd_reg)
            res.data = fwd_byte_reg;
        else
            res.data = mem_q;
    end

    `URTS_ASSERT_NOW(a_used_bound, 1'b1, used_reg <= FULL_CNT)
    `URTS_ASSERT_NOW(a_empty_ptrs, used_reg == '0, head_reg == tail_reg)
    `URTS_ASSERT_NEXT(a_gap_cleared, step && release_now, gap_reg == 8'd0)

endmodule

/* sv/uart_rx_with_rts_send_gate.sv */
// top level: uart receiver and rts send gate with request pipeline and output register
// One request is one serial-line tick and one result comes back for every request. A new
// request is taken every cycle while the output side keeps up. The first stage registers the
// receiver result and the send queue memory read at the edge that takes the request; the
// output register then loads from the first stage when the output side is free, and presents
// the result until it is taken. The queue memory needs no clearing pass after reset. When the
// output stalls with both stages full, in_stall rises in the same cycle; with the first stage
// empty, one more request is still taken. The user is to write bit_period and rts_holdoff only
// while no request is in flight; the block itself does not enforce this.
`include "uart_rx_with_rts_send_gate_macros.svh"
module uart_rx_with_rts_send_gate #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [urts_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [urts_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                line_bit,
    input  logic                                rts_n,
    input  logic [urts_pkg::DATA_W-1:0]         host_byte,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                rx_valid,
    output logic [urts_pkg::DATA_W-1:0]         rx_byte,
    output logic                                send_valid,
    output logic [urts_pkg::DATA_W-1:0]         send_byte,
    output logic                                host_dropped
);

    logic [urts_pkg::CFG_W-1:0] bit_period_reg;
    logic [urts_pkg::CFG_W-1:0] rts_holdoff_reg;

    logic                       s1_valid_reg;
    logic                       out_valid_reg;
    urts_pkg::rx_res_t          out_rx_reg;
    urts_pkg::send_res_t        out_send_reg;

    urts_pkg::rx_res_t          rx_res;
    urts_pkg::send_res_t        send_res;

    logic                       out_free, s1_move, s1_free, step;

    always_comb
    begin
        out_free = !out_valid_reg || !out_stall;
        s1_move  = s1_valid_reg && out_free;
        s1_free  = !s1_valid_reg || s1_move;
        step     = in_valid && s1_free;
    end

    assign in_stall = !s1_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_period_reg  <= urts_pkg::BIT_PERIOD_RST;
            rts_holdoff_reg <= urts_pkg::RTS_HOLDOFF_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                urts_pkg::CFG_BIT_PERIOD:  bit_period_reg  <= cfg_data;
                urts_pkg::CFG_RTS_HOLDOFF: rts_holdoff_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    urts_rx u_rx (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .line_bit   (line_bit),
        .bit_period (bit_period_reg),
        .res        (rx_res)
    );

    urts_send #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_send (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .rts_n       (rts_n),
        .host_byte   (host_byte),
        .rts_holdoff (rts_holdoff_reg),
        .res         (send_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
                s1_valid_reg <= step;
            if (out_free)
                out_valid_reg <= s1_move;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_rx_reg   <= rx_res;
            out_send_reg <= send_res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign rx_valid     = out_rx_reg.valid;
    assign rx_byte      = out_rx_reg.data;
    assign send_valid   = out_send_reg.valid;
    assign send_byte    = out_send_reg.data;
    assign host_dropped = out_send_reg.dropped;

    `URTS_ASSERT_NEXT(a_held_stage_kept, s1_valid_reg && !out_free, s1_valid_reg && out_valid_reg)
    `URTS_ASSERT_NOW(a_no_step_on_stall, in_stall, !step)
    `URTS_ASSERT_NEXT(a_out_kept_on_stall, out_valid_reg && out_stall, out_valid_reg && $stable(out_rx_reg) && $stable(out_send_reg))

endmodule

/* bench/testbench.sv */
// self-checking testbench for the uart receiver with rts send gate
`timescale 1ns / 100ps
module testbench;

    localparam int QDEPTH       = 16;
    localparam int LIMIT_CYCLES = 200000;
    localparam int SETTLE       = 4;

    typedef struct packed {
        urts_pkg::rx_res_t   rx;
        urts_pkg::send_res_t snd;
    } tick_res_t;

    typedef enum logic {
        ROW_TICK,
        ROW_REG
    } row_kind_t;

    typedef struct packed {
        row_kind_t                         kind;
        logic [urts_pkg::CFG_ADDR_W-1:0]   reg_idx;
        logic [urts_pkg::CFG_W-1:0]        reg_val;
        logic                              line;
        logic                              rts;
        logic [urts_pkg::DATA_W-1:0]       host;
        logic                              typed;
        tick_res_t                         want;
    } row_t;

    localparam tick_res_t RES_NONE    = '0;
    localparam tick_res_t RES_SEND_FF = {1'b0, 8'h00, 1'b1, 8'hFF, 1'b0};
    localparam tick_res_t RES_SEND_80 = {1'b0, 8'h00, 1'b1, 8'h80, 1'b0};
    localparam tick_res_t RES_RX_A5   = {1'b1, 8'hA5, 1'b0, 8'h00, 1'b0};

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            cfg_we    = 1'b0;
    logic [urts_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [urts_pkg::CFG_W-1:0]      cfg_data  = '0;
    logic                            in_valid  = 1'b0;
    logic                            in_stall;
    logic                            line_bit  = 1'b1;
    logic                            rts_n     = 1'b1;
    logic [urts_pkg::DATA_W-1:0]     host_byte = '0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic                            rx_valid;
    logic [urts_pkg::DATA_W-1:0]     rx_byte;
    logic                            send_valid;
    logic [urts_pkg::DATA_W-1:0]     send_byte;
    logic                            host_dropped;

    bit        gaps_on  = 1'b0;
    bit        stall_on = 1'b0;
    int        mismatch_count = 0;
    int        cycle_count    = 0;
    tick_res_t expected_ticks[$];
    tick_res_t got_res;
    logic      line_plan[$];

    // model state of the receiver and the send gate
    logic [urts_pkg::CFG_W-1:0]    m_bit_period = urts_pkg::BIT_PERIOD_RST;
    logic [urts_pkg::CFG_W-1:0]    m_holdoff    = urts_pkg::RTS_HOLDOFF_RST;
    urts_pkg::rx_phase_t           m_phase      = urts_pkg::PH_WAIT;
    logic [urts_pkg::TICK_W-1:0]   m_ticks      = urts_pkg::TICK_RST;
    logic [urts_pkg::BITS_W-1:0]   m_bits       = '0;
    logic [urts_pkg::DATA_W-1:0]   m_shift      = '0;
    logic                          m_armed      = 1'b0;
    logic [7:0]                    m_gap        = '0;
    logic [urts_pkg::DATA_W-1:0]   m_fifo [QDEPTH];
    int                            m_head       = 0;
    int                            m_tail       = 0;
    int                            m_used       = 0;

    row_t dir_rows [26] = '{
        '{ROW_TICK, urts_pkg::CFG_BIT_PERIOD,  8'd0, 1'b1, 1'b1, 8'h00, 1'b1, RES_NONE},
        '{ROW_TICK, urts_pkg::CFG_BIT_PERIOD,  8'd0, 1'b1, 1'b0, 8'h00, 1'b1, RES_NONE},
        '{ROW_TICK, urts_pkg::CFG_BIT_PERIOD,  8'd0, 1'b1, 1'b1, 8'hFF, 1'b1, RES_NONE},
        '{ROW_TICK, urts_pkg::CFG_BIT_PERIOD,  8'd0, 1'b1, 1'b1, 8'h01, 1'b1, RES_NONE},
        '{ROW_REG,  urts_pkg::CFG_RTS_HOLDOFF, 8'd0, 1'b1, 1'b1, 8'h00, 1'b0, RES_NONE},
        // request honored at once with zero holdoff
        '{ROW_TICK, urts_pkg::CFG_BIT_PERIOD,  8'd0, 1'b1, 1'b0, 8'h00, 1'b1, RES_NONE},
        '{ROW_TICK, urts_pkg::CFG_BIT_PERIOD,  8'd0, 1'b1, 1'b1, 8'h11, 1'b1, RES_SEND_FF},
        '{ROW_TICK, urts_pkg::CFG_BIT_PERIOD,  8'd0, 1'b1, 1'b0, 8'h00, 1'b0, RES_NONE},
        '{ROW_TICK, urts_pkg::CFG_BIT_PERIOD,  8'd0, 1'b1, 1'b0, 8'h00, 1'b0, RES_NONE},
        '{ROW_TICK, urts_pkg::CFG_BIT_PERIOD,  8'd0, 1'b1, 1'b0, 8'h00, 1'b0, RES_NONE},
        '{ROW_TICK, urts_pkg::CFG_BIT_PERIOD,  8'd0, 1'b1, 1'b1, 8'h00, 1'b0, RES_NONE},
        '{ROW_TICK, urts_pkg::CFG_BIT_PERIOD,  8'd0, 1'b1, 1'b0, 8'h00, 1'b0, RES_NONE},
        // armed while the queue is empty
        '{ROW_TICK, urts_pkg::CFG_BIT_PERIOD,  8'd0, 1'b1, 1'b1, 8'h00, 1'b1, RES_NONE},
        '{ROW_TICK, urts_pkg::CFG_BIT_PERIOD,  8'd0, 1'b1, 1'b0, 8'h00, 1'b0, RES_NONE},
        // byte into an empty queue leaves on the same tick
        '{ROW_TICK, urts_pkg::CFG_BIT_PERIOD,  8'd0, 1'b1, 1'b1, 8'h80, 1'b1, RES_SEND_80},
        '{ROW_REG,  urts_pkg::CFG_BIT_PERIOD,  8'd0, 1'b1, 1'b1, 8'h00, 1'b0, RES_NONE},
        // zero bit period: every tick after the start bit is a sample, byte 0xa5
        '{ROW_TICK, urts_pkg::CFG_BIT_PERIOD,  8'd0, 1'b0, 1'b1, 8'h00, 1'b1, RES_NONE},
        '{ROW_TICK, urts_pkg::CFG_BIT_PERIOD,  8'd0, 1'b1, 1'b1, 8'h00, 1'b0, RES_NONE},
        '{ROW_TICK, urts_pkg::CFG_BIT_PERIOD,  8'd0, 1'b0, 1'b1, 8'h00, 1'b0, RES_NONE},
        '{ROW_TICK, urts_pkg::CFG_BIT_PERIOD,  8'd0, 1'b1, 1'b1, 8'h00, 1'b0, RES_NONE},
        '{ROW_TICK, urts_pkg::CFG_BIT_PERIOD,  8'd0, 1'b0, 1'b1, 8'h00, 1'b0, RES_NONE},
        '{ROW_TICK, urts_pkg::CFG_BIT_PERIOD,  8'd0, 1'b0, 1'b1, 8'h00, 1'b0, RES_NONE},
        '{ROW_TICK, urts_pkg::CFG_BIT_PERIOD,  8'd0, 1'b1, 1'b1, 8'h00, 1'b0, RES_NONE},
        '{ROW_TICK, urts_pkg::CFG_BIT_PERIOD,  8'd0, 1'b0, 1'b1, 8'h00, 1'b0, RES_NONE},
        '{ROW_TICK, urts_pkg::CFG_BIT_PERIOD,  8'd0, 1'b1, 1'b1, 8'h00, 1'b1, RES_RX_A5},
        '{ROW_TICK, urts_pkg::CFG_BIT_PERIOD,  8'd0, 1'b1, 1'b1, 8'h00, 1'b1, RES_NONE}
    };

    uart_rx_with_rts_send_gate dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .line_bit     (line_bit),
        .rts_n        (rts_n),
        .host_byte    (host_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .rx_valid     (rx_valid),
        .rx_byte      (rx_byte),
        .send_valid   (send_valid),
        .send_byte    (send_byte),
        .host_dropped (host_dropped)
    );

    always #1 clk = ~clk;

    function automatic tick_res_t predict_tick(input logic lb, input logic rn,
                                               input logic [urts_pkg::DATA_W-1:0] hb);
        tick_res_t                   res;
        logic [urts_pkg::TICK_W-1:0] n;
        logic [urts_pkg::TICK_W-1:0] n_next;
        res = '0;
        if (hb != '0)
        begin
            if (m_used >= QDEPTH)
            begin
                res.snd.dropped = 1'b1;
            end
            else
            begin
                m_fifo[m_tail] = hb;
                m_tail = (m_tail + 1) % QDEPTH;
                m_used++;
            end
        end
        n = m_ticks;
        if (m_gap != urts_pkg::GAP_MAX)
            m_gap++;
        if (m_armed)
        begin
            if (m_used != 0)
            begin
                res.snd.valid = 1'b1;
                res.snd.data  = m_fifo[m_head];
                m_head = (m_head + 1) % QDEPTH;
                m_used--;
                m_gap = '0;
            end
            m_armed = 1'b0;
        end
        if (!rn && m_gap > m_holdoff)
            m_armed = 1'b1;
        n_next = (n == urts_pkg::TICK_MAX) ? urts_pkg::TICK_MAX
                                           : n + urts_pkg::TICK_W'(1);
        case (m_phase)
            urts_pkg::PH_DATA:
            begin
                if (n >= m_bit_period)
                begin
                    m_shift = {lb, m_shift[urts_pkg::DATA_W-1:1]};
                    n_next  = urts_pkg::TICK_W'(1);
                    m_bits  = m_bits + urts_pkg::BITS_W'(1);
                    if (m_bits >= urts_pkg::DATA_BITS)
                    begin
                        if (m_shift != '0)
                        begin
                            res.rx.valid = 1'b1;
                            res.rx.data  = m_shift;
                        end
                        m_phase = urts_pkg::PH_STOP;
                    end
                end
            end
            urts_pkg::PH_STOP:
            begin
                if (n >= m_bit_period)
                    m_phase = urts_pkg::PH_WAIT;
            end
            default:
            begin
                m_phase = urts_pkg::PH_WAIT;
                if (!lb)
                begin
                    m_phase = urts_pkg::PH_DATA;
                    n_next  = '0;
                    m_bits  = '0;
                end
            end
        endcase
        m_ticks = n_next;
        return res;
    endfunction

    function automatic void check_field(input string name,
                                        input logic [urts_pkg::DATA_W-1:0] want,
                                        input logic [urts_pkg::DATA_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_ticks.size() == 0)
            begin
                $display("%0t: result with no request pending, expected none, got %0h %0h %0h %0h %0h",
                         $time, rx_valid, rx_byte, send_valid, send_byte, host_dropped);
                mismatch_count++;
            end
            else
            begin
                got_res = expected_ticks.pop_front();
                check_field("rx_valid", urts_pkg::DATA_W'(got_res.rx.valid),
                            urts_pkg::DATA_W'(rx_valid));
                check_field("rx_byte", got_res.rx.data, rx_byte);
                check_field("send_valid", urts_pkg::DATA_W'(got_res.snd.valid),
                            urts_pkg::DATA_W'(send_valid));
                check_field("send_byte", got_res.snd.data, send_byte);
                check_field("host_dropped", urts_pkg::DATA_W'(got_res.snd.dropped),
                            urts_pkg::DATA_W'(host_dropped));
            end
        end
    end

    always @(negedge clk)
        out_stall <= stall_on && ($urandom_range(99) < 12);

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_tick(input logic lb, input logic rn,
                             input logic [urts_pkg::DATA_W-1:0] hb,
                             input logic typed, input tick_res_t want);
        tick_res_t model_res;
        while (gaps_on && $urandom_range(99) < 12)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        line_bit  = lb;
        rts_n     = rn;
        host_byte = hb;
        in_valid  = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        model_res = predict_tick(lb, rn, hb);
        expected_ticks.push_back(typed ? want : model_res);
        @(negedge clk);
    endtask

    // wait until every request has its result and the pipeline is quiet
    task automatic settle_idle();
        in_valid = 1'b0;
        while (expected_ticks.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input logic [urts_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [urts_pkg::CFG_W-1:0] val);
        cfg_addr = idx;
        cfg_data = val;
        cfg_we   = 1'b1;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == urts_pkg::CFG_BIT_PERIOD)
            m_bit_period = val;
        else
            m_holdoff = val;
    endtask

    task automatic run_phase(input logic [urts_pkg::CFG_W-1:0] bp,
                             input logic [urts_pkg::CFG_W-1:0] hold,
                             input int count, input bit quiet);
        logic [urts_pkg::DATA_W-1:0] hb;
        logic [urts_pkg::DATA_W-1:0] frame;
        logic                        rn;
        int                          burst_left;
        int                          span;
        int                          nbits;
        int                          pick;
        settle_idle();
        write_reg(urts_pkg::CFG_BIT_PERIOD, bp);
        write_reg(urts_pkg::CFG_RTS_HOLDOFF, hold);
        gaps_on    = !quiet;
        stall_on   = !quiet;
        burst_left = 0;
        span       = (bp == 0) ? 1 : int'(bp);
        line_plan.delete();
        for (int k = 0; k < count; k++)
        begin
            if (line_plan.size() == 0)
            begin
                pick = $urandom_range(99);
                if (pick < 70)
                begin
                    case ($urandom_range(9))
                        0:       frame = 8'h00;
                        1:       frame = 8'h11;
                        2:       frame = 8'hFF;
                        default: frame = 8'($urandom_range(255));
                    endcase
                    // some frames break off early
                    nbits = ($urandom_range(9) == 0) ? $urandom_range(7) : 8;
                    repeat (span) line_plan.push_back(1'b0);
                    for (int b = 0; b < nbits; b++)
                        repeat (span) line_plan.push_back(frame[b]);
                    repeat (span + $urandom_range(2)) line_plan.push_back(1'b1);
                end
                else if (pick < 85)
                begin
                    repeat ($urandom_range(1, 8)) line_plan.push_back(1'b1);
                end
                else
                begin
                    repeat ($urandom_range(1, 6)) line_plan.push_back(1'($urandom_range(1)));
                end
            end
            // bursts of host bytes fill the queue up to overflow
            if (burst_left > 0)
            begin
                burst_left--;
                hb = 8'($urandom_range(1, 255));
            end
            else if ($urandom_range(99) < 3)
            begin
                burst_left = $urandom_range(10, 24);
                hb = 8'($urandom_range(1, 255));
            end
            else
            begin
                hb = ($urandom_range(99) < 15) ? 8'($urandom_range(1, 255)) : 8'h00;
            end
            rn = ($urandom_range(99) < 60) ? 1'b0 : 1'b1;
            send_tick(line_plan.pop_front(), rn, hb, 1'b0, RES_NONE);
        end
    endtask

    initial
    begin
        repeat (5) @(negedge clk);
        rst_n    = 1'b1;
        gaps_on  = 1'b1;
        stall_on = 1'b1;
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_REG)
            begin
                settle_idle();
                write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
            end
            else
            begin
                send_tick(dir_rows[i].line, dir_rows[i].rts, dir_rows[i].host,
                          dir_rows[i].typed, dir_rows[i].want);
            end
        end
        run_phase(8'd3,   8'd0,   80,  1'b0);
        run_phase(8'd2,   8'd255, 50,  1'b0);
        run_phase(8'd255, 8'd0,   40,  1'b0);
        run_phase(8'd4,   8'd5,   100, 1'b1);
        run_phase(8'd1,   8'd2,   50,  1'b0);
        run_phase(8'd0,   8'd1,   40,  1'b0);
        run_phase(8'd6,   8'd30,  90,  1'b0);
        run_phase(8'd8,   8'd10,  60,  1'b0);
        settle_idle();
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
